// ----- rtl/core/dersc_pkg.sv -----
// shared types, result codes and block size helper for the directory record scanner
// no dependencies; used by dersc_out_if, dersc_cfg_if, dersc_parse and dir_entry_record_scanner
package dersc_pkg;

  localparam int MAX_BLOCK_BYTES = 4096;
  localparam int HEADER_BYTES    = 8;
  localparam int BASE_BLOCK      = 1024;
  localparam int POS_W           = 12;
  localparam int BS_W            = POS_W + 1;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 8;

  // result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_NAME    = 2'd1;
  localparam logic [1:0] KIND_CORRUPT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_LOG   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILETYPE_ENABLED = 2'd1;

  typedef struct packed {
    logic [1:0] block_size_log;
    logic       filetype_enabled;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        kind;
    logic [31:0]       inode_number;
    logic [7:0]        name_length;
    logic [7:0]        entry_type;
    logic [POS_W-1:0]  entry_offset;
    logic [7:0]        name_byte;
    logic              last_of_entry;
  } result_t;

  // block size in bytes, log above 2 acts as 2
  function automatic logic [BS_W-1:0] block_bytes(input logic [1:0] lg);
    logic [1:0]      lg_c;
    logic [BS_W-1:0] bs;
    lg_c = (lg > 2'd2) ? 2'd2 : lg;
    bs   = BS_W'(BASE_BLOCK) << lg_c;
    if (bs > BS_W'(MAX_BLOCK_BYTES)) begin
      bs = BS_W'(MAX_BLOCK_BYTES);
    end
    return bs;
  endfunction

endpackage

// ----- rtl/core/dersc_in_if.sv -----
// input byte channel of the directory record scanner
// depends on nothing
interface dersc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// ----- rtl/core/dersc_out_if.sv -----
// result channel of the directory record scanner
// depends on dersc_pkg for the offset width
interface dersc_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [31:0]                inode_number;
  logic [7:0]                 name_length;
  logic [7:0]                 entry_type;
  logic [dersc_pkg::POS_W-1:0] entry_offset;
  logic [7:0]                 name_byte;
  logic                       last_of_entry;

  modport source (output valid, output kind, output inode_number, output name_length,
                  output entry_type, output entry_offset, output name_byte,
                  output last_of_entry, input ready);
  modport sink   (input valid, input kind, input inode_number, input name_length,
                  input entry_type, input entry_offset, input name_byte,
                  input last_of_entry, output ready);
endinterface

// ----- rtl/core/dersc_cfg_if.sv -----
// configuration write channel of the directory record scanner
// depends on dersc_pkg for index and data widths
interface dersc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dersc_pkg::CFG_IDX_W-1:0]  index;
  logic [dersc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/dersc_parse.sv -----
// record state and per-byte decode of the directory record scanner
// depends on dersc_pkg; result is combinational, registered by the top level
module dersc_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  dersc_pkg::cfg_t     cfg,
  output dersc_pkg::result_t  res
);

  logic [dersc_pkg::POS_W-1:0] byte_pos_r, byte_pos_nxt;
  logic [dersc_pkg::POS_W-1:0] rec_start_r, rec_start_nxt;
  logic [31:0]                 inode_r, inode_nxt;
  logic [15:0]                 rec_len_r, rec_len_nxt;
  logic [7:0]                  name_len_r, name_len_nxt;
  logic [7:0]                  type_r, type_nxt;
  logic [7:0]                  name_rem_r, name_rem_nxt;
  logic                        dead_r, dead_nxt;

  logic [dersc_pkg::POS_W-1:0] rel;
  logic [dersc_pkg::BS_W-1:0]  bs;
  logic                        active;
  logic                        len_bad;

  assign rel = byte_pos_r - rec_start_r;
  assign bs  = dersc_pkg::block_bytes(cfg.block_size_log);
  assign active = !dead_r &&
                  (({1'b0, rec_start_r} + dersc_pkg::BS_W'(dersc_pkg::HEADER_BYTES)) <= bs);
  assign len_bad = (rec_len_r < 16'(dersc_pkg::HEADER_BYTES)) || (rec_len_r[1:0] != 2'b00) ||
                   (({5'b0, rec_start_r} + {1'b0, rec_len_r}) > {4'b0, bs});

  always_comb begin
    byte_pos_nxt  = byte_pos_r;
    rec_start_nxt = rec_start_r;
    inode_nxt     = inode_r;
    rec_len_nxt   = rec_len_r;
    name_len_nxt  = name_len_r;
    type_nxt      = type_r;
    name_rem_nxt  = name_rem_r;
    dead_nxt      = dead_r;
    res           = '0;

    if (active) begin
      priority if (rel < 12'd4) begin
        if (rel == 12'd0) begin
          inode_nxt = {24'b0, data_byte};
        end else begin
          inode_nxt = inode_r | ({24'b0, data_byte} << {rel[1:0], 3'b000});
        end
      end else if (rel == 12'd4) begin
        rec_len_nxt = {8'b0, data_byte};
      end else if (rel == 12'd5) begin
        rec_len_nxt = rec_len_r | {data_byte, 8'b0};
      end else if (rel == 12'd6) begin
        name_len_nxt = data_byte;
      end else if (rel == 12'd7) begin
        type_nxt     = data_byte;
        name_rem_nxt = '0;
        if (len_bad) begin
          dead_nxt         = 1'b1;
          res.valid        = 1'b1;
          res.kind         = dersc_pkg::KIND_CORRUPT;
          res.entry_offset = rec_start_r;
        end else if (inode_r != 32'd0 && name_len_r != 8'd0 &&
                     {8'b0, name_len_r} <= (rec_len_r - 16'(dersc_pkg::HEADER_BYTES))) begin
          name_rem_nxt     = name_len_r;
          res.valid        = 1'b1;
          res.kind         = dersc_pkg::KIND_HEADER;
          res.inode_number = inode_r;
          res.name_length  = name_len_r;
          res.entry_type   = cfg.filetype_enabled ? data_byte : 8'd0;
          res.entry_offset = rec_start_r;
        end
      end else if (name_rem_r != 8'd0) begin
        res.valid         = 1'b1;
        res.kind          = dersc_pkg::KIND_NAME;
        res.inode_number  = inode_r;
        res.name_length   = name_len_r;
        res.entry_type    = cfg.filetype_enabled ? type_r : 8'd0;
        res.entry_offset  = rec_start_r;
        res.name_byte     = data_byte;
        res.last_of_entry = (name_rem_r == 8'd1);
        name_rem_nxt      = name_rem_r - 8'd1;
      end

      // last byte of a good record: next record starts here
      if (!dead_nxt && rel >= 12'd7 && ({4'b0, rel} + 16'd1) == rec_len_r) begin
        rec_start_nxt = rec_start_r + rec_len_r[dersc_pkg::POS_W-1:0];
        name_rem_nxt  = '0;
      end
    end

    // end of block
    if (({1'b0, byte_pos_r} + dersc_pkg::BS_W'(1)) >= bs) begin
      byte_pos_nxt  = '0;
      rec_start_nxt = '0;
      dead_nxt      = 1'b0;
      name_rem_nxt  = '0;
    end else begin
      byte_pos_nxt = byte_pos_r + dersc_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= '0;
      rec_start_r <= '0;
      inode_r     <= '0;
      rec_len_r   <= '0;
      name_len_r  <= '0;
      type_r      <= '0;
      name_rem_r  <= '0;
      dead_r      <= 1'b0;
    end else if (step) begin
      byte_pos_r  <= byte_pos_nxt;
      rec_start_r <= rec_start_nxt;
      inode_r     <= inode_nxt;
      rec_len_r   <= rec_len_nxt;
      name_len_r  <= name_len_nxt;
      type_r      <= type_nxt;
      name_rem_r  <= name_rem_nxt;
      dead_r      <= dead_nxt;
    end
  end

endmodule

// ----- rtl/core/dir_entry_record_scanner.sv -----
// top level of the directory record scanner: input stage, config registers, result register
// depends on dersc_pkg, dersc_in_if, dersc_out_if, dersc_cfg_if and dersc_parse
//
//  channel   dir  beat payload
//  in_chan   in   data_byte (8): next raw byte of the directory block stream
//  out_chan  out  kind, inode_number, name_length, entry_type, entry_offset,
//                 name_byte, last_of_entry: zero or one result per byte
//  cfg_chan  in   index (2), data (8): 0 block_size_log, 1 filetype_enabled
//
// one byte per cycle sustained while out_chan is not stalled; a taken byte first sits
// in the input register, then decodes into the result register
// rst_n is synchronous: clears record state, block_size_log to 0, filetype_enabled to 1
// a stalled result holds the result register and the byte in the input register;
// in_chan.ready stays high while the input register is empty or the result register
// frees up in the same cycle, otherwise it drops
// cfg_chan.ready is always high
module dir_entry_record_scanner (
  input  logic         clk,
  input  logic         rst_n,
  dersc_in_if.sink     in_chan,
  dersc_out_if.source  out_chan,
  dersc_cfg_if.sink    cfg_chan
);

  // configuration registers
  dersc_pkg::cfg_t cfg_r;

  // input stage
  logic       in_v_r;
  logic [7:0] in_byte_r;

  // result register
  dersc_pkg::result_t res;
  dersc_pkg::result_t out_r;

  logic out_free;
  logic advance;

  assign out_free = !out_r.valid || out_chan.ready;
  assign advance  = in_v_r && out_free;

  assign in_chan.ready  = !in_v_r || advance;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_size_log   <= 2'd0;
      cfg_r.filetype_enabled <= 1'b1;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        dersc_pkg::REG_BLOCK_SIZE_LOG:   cfg_r.block_size_log   <= cfg_chan.data[1:0];
        dersc_pkg::REG_FILETYPE_ENABLED: cfg_r.filetype_enabled <= cfg_chan.data[0];
        default: ;  // no register at other indexes
      endcase
    end
  end

  // input beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_byte_r <= in_chan.data_byte;
    end
  end

  dersc_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (in_byte_r),
    .cfg       (cfg_r),
    .res       (res)
  );

  // result register: load on a decoded result, drain when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (advance && res.valid) begin
      out_r <= res;
    end else if (out_chan.ready) begin
      out_r.valid <= 1'b0;
    end
  end

  assign out_chan.valid         = out_r.valid;
  assign out_chan.kind          = out_r.kind;
  assign out_chan.inode_number  = out_r.inode_number;
  assign out_chan.name_length   = out_r.name_length;
  assign out_chan.entry_type    = out_r.entry_type;
  assign out_chan.entry_offset  = out_r.entry_offset;
  assign out_chan.name_byte     = out_r.name_byte;
  assign out_chan.last_of_entry = out_r.last_of_entry;

  // corrupt beats carry only the record offset
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.kind == dersc_pkg::KIND_CORRUPT) |->
      (out_chan.inode_number == 32'd0 && out_chan.name_length == 8'd0 &&
       out_chan.name_byte == 8'd0 && !out_chan.last_of_entry))
    else $error("corrupt beat with nonzero entry fields");

  // the end flag only rides on name beats
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.last_of_entry) |-> (out_chan.kind == dersc_pkg::KIND_NAME))
    else $error("last_of_entry set outside a name beat");

  // a header always announces a live entry with a name
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.kind == dersc_pkg::KIND_HEADER) |->
      (out_chan.inode_number != 32'd0 && out_chan.name_length != 8'd0))
    else $error("header beat for an empty entry");

endmodule
